// ===== hw/rtl/obstacle_speed_steer_control_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OBSTACLE_SPEED_STEER_CONTROL_CORE_DEFINES_SVH
`define OBSTACLE_SPEED_STEER_CONTROL_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define OSSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define OSSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error(msg);
`else
`define OSSC_ASSERT(label, prop, msg)
`define OSSC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/ossc_pkg.sv =====
// ----------------------------------------------------------------------------
// Obstacle speed/steer control package
// Field widths, register indexes and reset values shared by the block.
// ----------------------------------------------------------------------------
package ossc_pkg;

    localparam int DIST_W_DEF = 12;
    localparam int DIST_CFG_W = 12;
    localparam int DUTY_W     = 8;
    localparam int FRAC_W     = 8;
    localparam int ALPHA_W    = 9;
    localparam int GAIN_W     = 12;
    localparam int SPEED_W    = 16;
    localparam int BIAS_Q_W   = SPEED_W + 1;
    localparam int BIAS_OUT_W = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_STOP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BIAS = 3'd6;

    localparam logic [DIST_CFG_W-1:0] RST_STOP     = 12'd200;
    localparam logic [DIST_CFG_W-1:0] RST_FULL     = 12'd1000;
    localparam logic [DUTY_W-1:0]     RST_MIN_DUTY = 8'd80;
    localparam logic [DUTY_W-1:0]     RST_MAX_DUTY = 8'd200;
    localparam logic [ALPHA_W-1:0]    RST_ALPHA    = 9'd51;
    localparam logic [GAIN_W-1:0]     RST_GAIN     = 12'd128;
    localparam logic [DUTY_W-1:0]     RST_MAX_BIAS = 8'd60;

    typedef struct packed {
        logic [DIST_CFG_W-1:0] stop;
        logic [DIST_CFG_W-1:0] full;
        logic [DUTY_W-1:0]     min_duty;
        logic [DUTY_W-1:0]     max_duty;
        logic [ALPHA_W-1:0]    alpha;
        logic [GAIN_W-1:0]     gain;
        logic [DUTY_W-1:0]     max_bias;
    } t_cfg;

endpackage

// ===== hw/rtl/ossc_in_if.sv =====
// ----------------------------------------------------------------------------
// Sensor request channel
// Valid/ready channel carrying the three distance readings.
// ----------------------------------------------------------------------------
interface ossc_in_if import ossc_pkg::*; #(
    parameter int DW = DIST_W_DEF
) ();
    logic          valid;
    logic          ready;
    logic [DW-1:0] center_distance;
    logic [DW-1:0] left_distance;
    logic [DW-1:0] right_distance;

    modport source (
        output valid, center_distance, left_distance, right_distance,
        input  ready
    );
    modport sink (
        input  valid, center_distance, left_distance, right_distance,
        output ready
    );
endinterface

// ===== hw/rtl/ossc_out_if.sv =====
// ----------------------------------------------------------------------------
// Drive command channel
// Valid/ready channel carrying wheel duties, speeds and steering bias.
// ----------------------------------------------------------------------------
interface ossc_out_if import ossc_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [DUTY_W-1:0]            left_duty;
    logic [DUTY_W-1:0]            right_duty;
    logic [SPEED_W-1:0]           smoothed_speed;
    logic [SPEED_W-1:0]           target_speed;
    logic signed [BIAS_OUT_W-1:0] steer_bias;

    modport source (
        output valid, left_duty, right_duty, smoothed_speed, target_speed, steer_bias,
        input  ready
    );
    modport sink (
        input  valid, left_duty, right_duty, smoothed_speed, target_speed, steer_bias,
        output ready
    );
endinterface

// ===== hw/rtl/obstacle_speed_steer_control_core.sv =====
// ----------------------------------------------------------------------------
// Obstacle speed and steering control core
// Distance-driven target speed, smoothed speed and differential wheel duties.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  i_in     in   valid/ready          center, left, right distance
//  o_out    out  valid/ready          left/right duty, speeds, steer bias
//  i_cfg    in   write enable only    register index, write data
//
//  One request at a time. Ramp zone: timing set by the serial 8-bit ramp
//  multiply, the 16-bit restoring divider and the 9-bit filter multiply.
//  Stop and full zones: timing set by the 12-bit serial steering multiply.
//  Reset is synchronous and clears config to defaults and the speed to
//  zero. A held result does not block the next request; only the final
//  load waits for the output register to free up.
// ----------------------------------------------------------------------------
`include "obstacle_speed_steer_control_core_defines.svh"

module obstacle_speed_steer_control_core import ossc_pkg::*; #(
    parameter int DISTANCE_WIDTH = DIST_W_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ossc_in_if.sink               i_in,
    ossc_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int DW   = DISTANCE_WIDTH;
    localparam int EW   = (DW > DIST_CFG_W) ? DW : DIST_CFG_W;
    localparam int RP_W = DIST_CFG_W + 1 + DUTY_W;
    localparam int BP_W = DW + 1 + GAIN_W;
    localparam int FP_W = SPEED_W + 1 + ALPHA_W;
    localparam int FS_W = FP_W - FRAC_W;
    localparam int SS_W = FS_W + 1;
    localparam int DQ_W = SPEED_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAMP_MUL,
        S_RAMP_DIV,
        S_FILT_GO,
        S_FILT_MUL,
        S_FINISH
    } t_state;

    t_state                      r_state;
    t_cfg                        r_cfg;
    logic [SPEED_W-1:0]          r_speed;
    logic [SPEED_W-1:0]          r_target;
    logic signed [BIAS_Q_W-1:0]  r_bias;
    logic                        r_bias_ok;
    logic                        r_out_valid;
    logic [DUTY_W-1:0]           r_out_left;
    logic [DUTY_W-1:0]           r_out_right;
    logic [SPEED_W-1:0]          r_out_speed;
    logic [SPEED_W-1:0]          r_out_target;
    logic signed [BIAS_OUT_W-1:0] r_out_bias;

    logic                        w_accept;
    logic [EW-1:0]               w_c_ext;
    logic [EW-1:0]               w_stop_ext;
    logic [EW-1:0]               w_full_ext;
    logic [EW-1:0]               w_cdiff;
    logic                        w_le_stop;
    logic                        w_ge_full;
    logic                        w_neg;
    logic [DUTY_W-1:0]           w_mag;
    logic signed [DW:0]          w_lr;
    logic                        w_ramp_start;
    logic                        w_ramp_done;
    logic signed [RP_W-1:0]      w_ramp_prod;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [SPEED_W-1:0]          w_quot;
    logic [SPEED_W-1:0]          w_min_q;
    logic                        w_bias_done;
    logic signed [BP_W-1:0]      w_bias_prod;
    logic signed [BP_W-1:0]      w_lim;
    logic signed [BP_W-1:0]      w_nlim;
    logic                        w_filt_start;
    logic                        w_filt_done;
    logic signed [SPEED_W:0]     w_filt_a;
    logic signed [FP_W-1:0]      w_filt_prod;
    logic signed [FP_W-1:0]      w_filt_rnd;
    logic signed [SS_W-1:0]      w_spd_sum;
    logic [SPEED_W-1:0]          w_spd_sat;
    logic signed [DQ_W-1:0]      w_lq;
    logic signed [DQ_W-1:0]      w_rq;
    logic signed [BIAS_Q_W-1:0]  w_bias_rnd;
    logic                        w_out_free;
    logic                        w_load;

    function automatic logic [DUTY_W-1:0] duty_of(input logic signed [DQ_W-1:0] q);
        if (q[DQ_W-1] || (q == '0)) begin
            return '0;
        end else if (q[DQ_W-2]) begin
            return '1;
        end
        return q[DQ_W-3:FRAC_W];
    endfunction

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop     <= RST_STOP;
            r_cfg.full     <= RST_FULL;
            r_cfg.min_duty <= RST_MIN_DUTY;
            r_cfg.max_duty <= RST_MAX_DUTY;
            r_cfg.alpha    <= RST_ALPHA;
            r_cfg.gain     <= RST_GAIN;
            r_cfg.max_bias <= RST_MAX_BIAS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STOP:     r_cfg.stop     <= i_cfg_data[DIST_CFG_W-1:0];
                REG_FULL:     r_cfg.full     <= i_cfg_data[DIST_CFG_W-1:0];
                REG_MIN_DUTY: r_cfg.min_duty <= i_cfg_data[DUTY_W-1:0];
                REG_MAX_DUTY: r_cfg.max_duty <= i_cfg_data[DUTY_W-1:0];
                REG_ALPHA:    r_cfg.alpha    <= i_cfg_data[ALPHA_W-1:0];
                REG_GAIN:     r_cfg.gain     <= i_cfg_data[GAIN_W-1:0];
                REG_MAX_BIAS: r_cfg.max_bias <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_c_ext    = EW'(i_in.center_distance);
    assign w_stop_ext = EW'(r_cfg.stop);
    assign w_full_ext = EW'(r_cfg.full);
    assign w_cdiff    = w_c_ext - w_stop_ext;
    assign w_le_stop  = (w_c_ext <= w_stop_ext);
    assign w_ge_full  = (w_c_ext >= w_full_ext);
    assign w_neg      = (r_cfg.max_duty < r_cfg.min_duty);
    assign w_mag      = w_neg ? (r_cfg.min_duty - r_cfg.max_duty)
                              : (r_cfg.max_duty - r_cfg.min_duty);
    assign w_lr       = $signed({1'b0, i_in.right_distance}) - $signed({1'b0, i_in.left_distance});

    assign w_ramp_start = w_accept && !w_le_stop && !w_ge_full;
    assign w_div_start  = (r_state == S_RAMP_MUL) && w_ramp_done;
    assign w_filt_start = (r_state == S_FILT_GO) && (r_target != '0);
    assign w_filt_a     = $signed({1'b0, r_target}) - $signed({1'b0, r_speed});
    assign w_min_q      = {r_cfg.min_duty, {FRAC_W{1'b0}}};

    ossc_ser_mul #(
        .A_W (DIST_CFG_W + 1),
        .B_W (DUTY_W)
    ) u_ramp_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ramp_start),
        .i_a     ($signed({1'b0, w_cdiff[DIST_CFG_W-1:0]})),
        .i_b     (w_mag),
        .o_done  (w_ramp_done),
        .o_prod  (w_ramp_prod)
    );

    ossc_ser_div #(
        .R_W (DIST_CFG_W),
        .Q_W (SPEED_W)
    ) u_ramp_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_rem   (w_ramp_prod[FRAC_W +: DIST_CFG_W]),
        .i_num   ({w_ramp_prod[FRAC_W-1:0], {(SPEED_W-FRAC_W){1'b0}}}),
        .i_den   (r_cfg.full - r_cfg.stop),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    ossc_ser_mul #(
        .A_W (DW + 1),
        .B_W (GAIN_W)
    ) u_bias_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_a     (w_lr),
        .i_b     (r_cfg.gain),
        .o_done  (w_bias_done),
        .o_prod  (w_bias_prod)
    );

    ossc_ser_mul #(
        .A_W (SPEED_W + 1),
        .B_W (ALPHA_W)
    ) u_filt_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_filt_start),
        .i_a     (w_filt_a),
        .i_b     (r_cfg.alpha),
        .o_done  (w_filt_done),
        .o_prod  (w_filt_prod)
    );

    // clamp limits for the steering product
    assign w_lim  = $signed({{(BP_W-SPEED_W){1'b0}}, r_cfg.max_bias, {FRAC_W{1'b0}}});
    assign w_nlim = -w_lim;

    // round the filter step toward zero, then saturate the new speed
    assign w_filt_rnd = w_filt_prod
                      + $signed({{(FP_W-FRAC_W){1'b0}}, {FRAC_W{w_filt_prod[FP_W-1]}}});
    assign w_spd_sum  = $signed({{(SS_W-SPEED_W){1'b0}}, r_speed})
                      + $signed({w_filt_rnd[FP_W-1], w_filt_rnd[FP_W-1:FRAC_W]});
    always_comb begin
        if (w_spd_sum[SS_W-1]) begin
            w_spd_sat = '0;
        end else if (w_spd_sum[SS_W-2:SPEED_W] != '0) begin
            w_spd_sat = '1;
        end else begin
            w_spd_sat = w_spd_sum[SPEED_W-1:0];
        end
    end

    assign w_lq = $signed({2'b00, r_speed}) + $signed({r_bias[BIAS_Q_W-1], r_bias});
    assign w_rq = $signed({2'b00, r_speed}) - $signed({r_bias[BIAS_Q_W-1], r_bias});
    assign w_bias_rnd = r_bias
                      + $signed({{(BIAS_Q_W-FRAC_W){1'b0}}, {FRAC_W{r_bias[BIAS_Q_W-1]}}});
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_load     = (r_state == S_FINISH) && r_bias_ok && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_speed     <= '0;
            r_bias_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            if (w_bias_done) begin
                r_bias_ok <= 1'b1;
                if (w_bias_prod > w_lim) begin
                    r_bias <= w_lim[BIAS_Q_W-1:0];
                end else if (w_bias_prod < w_nlim) begin
                    r_bias <= w_nlim[BIAS_Q_W-1:0];
                end else begin
                    r_bias <= w_bias_prod[BIAS_Q_W-1:0];
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_ramp_start) begin
                            r_state <= S_RAMP_MUL;
                        end else begin
                            r_target <= w_le_stop ? '0 : {r_cfg.max_duty, {FRAC_W{1'b0}}};
                            r_state  <= S_FILT_GO;
                        end
                    end
                end
                S_RAMP_MUL: begin
                    if (w_ramp_done) begin
                        r_state <= S_RAMP_DIV;
                    end
                end
                S_RAMP_DIV: begin
                    if (w_div_done) begin
                        r_target <= w_neg ? (w_min_q - w_quot) : (w_min_q + w_quot);
                        r_state  <= S_FILT_GO;
                    end
                end
                S_FILT_GO: begin
                    if (r_target == '0) begin
                        r_speed <= '0;
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_FILT_MUL;
                    end
                end
                S_FILT_MUL: begin
                    if (w_filt_done) begin
                        r_speed <= w_spd_sat;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_load) begin
                        r_out_valid  <= 1'b1;
                        r_out_left   <= (r_speed == '0) ? '0 : duty_of(w_lq);
                        r_out_right  <= (r_speed == '0) ? '0 : duty_of(w_rq);
                        r_out_speed  <= r_speed;
                        r_out_target <= r_target;
                        r_out_bias   <= w_bias_rnd[BIAS_Q_W-1:FRAC_W];
                        r_bias_ok    <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.left_duty      = r_out_left;
    assign o_out.right_duty     = r_out_right;
    assign o_out.smoothed_speed = r_out_speed;
    assign o_out.target_speed   = r_out_target;
    assign o_out.steer_bias     = r_out_bias;

    `OSSC_ASSERT(a_out_from_finish, $rose(o_out.valid) |-> ($past(r_state) == S_FINISH), "result loaded outside finish")
    `OSSC_ASSERT(a_div_in_ramp, w_div_done |-> (r_state == S_RAMP_DIV), "divider finished outside ramp")
    `OSSC_ASSERT(a_zero_speed_duty, (o_out.valid && (o_out.smoothed_speed == '0)) |-> ((o_out.left_duty == '0) && (o_out.right_duty == '0)), "nonzero duty at zero speed")
    `OSSC_ASSERT(a_zero_target_speed, (o_out.valid && (o_out.target_speed == '0)) |-> (o_out.smoothed_speed == '0), "speed kept with zero target")
    `OSSC_ASSERT_NEXT(a_accept_busy, w_accept, !i_in.ready, "request taken while busy")

endmodule

// ===== hw/rtl/ossc_ser_mul.sv =====
// ----------------------------------------------------------------------------
// Serial multiplier
// Signed by unsigned shift-add product, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ossc_ser_mul import ossc_pkg::*; #(
    parameter int A_W = DIST_CFG_W + 1,
    parameter int B_W = DUTY_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [A_W-1:0]    i_a,
    input  logic        [B_W-1:0]    i_b,
    output logic                     o_done,
    output logic signed [A_W+B_W-1:0] o_prod
);
    localparam int CNT_W = $clog2(B_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic signed [A_W-1:0] r_a;
    logic signed [A_W:0]   r_acc;
    logic [B_W-1:0]      r_b;
    logic signed [A_W:0]   w_add;
    logic signed [A_W:0]   w_sum;

    assign w_add = r_b[0] ? $signed({r_a[A_W-1], r_a}) : '0;
    assign w_sum = r_acc + w_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= w_sum >>> 1;
            r_b   <= {w_sum[0], r_b[B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = $signed({r_acc[A_W-1:0], r_b});

endmodule

// ===== hw/rtl/ossc_ser_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, remainder kept below divisor.
// ----------------------------------------------------------------------------
module ossc_ser_div import ossc_pkg::*; #(
    parameter int R_W = DIST_CFG_W,
    parameter int Q_W = SPEED_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [R_W-1:0] i_rem,
    input  logic [Q_W-1:0] i_num,
    input  logic [R_W-1:0] i_den,
    output logic           o_done,
    output logic [Q_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(Q_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [R_W-1:0]   r_rem;
    logic [R_W-1:0]   r_den;
    logic [Q_W-1:0]   r_num;
    logic [R_W:0]     w_shift;
    logic [R_W+1:0]   w_trial;
    logic             w_ge;

    assign w_shift = {r_rem, r_num[Q_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_den};
    assign w_ge    = !w_trial[R_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[R_W-1:0] : w_shift[R_W-1:0];
            r_num <= {r_num[Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ===== bench/ossc_drive_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Drive command checker
// Tracks register writes and sensor requests, works out each expected drive
// command, and compares every accepted drive command field by field.
// ----------------------------------------------------------------------------
module ossc_drive_checker import ossc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ossc_in_if                    in_ch,
    ossc_out_if                   out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [DUTY_W-1:0]            left_duty;
        logic [DUTY_W-1:0]            right_duty;
        logic [SPEED_W-1:0]           smoothed_speed;
        logic [SPEED_W-1:0]           target_speed;
        logic signed [BIAS_OUT_W-1:0] steer_bias;
    } t_drive;

    t_cfg               cfg;
    logic [SPEED_W-1:0] speed_q88;
    t_drive             drive_q[$];
    t_drive             want;
    int                 errors  = 0;
    int                 checked = 0;

    function automatic longint q8_trunc(input longint v);
        if (v < 0) begin
            return -((-v) >> FRAC_W);
        end
        return v >> FRAC_W;
    endfunction

    function automatic longint wheel_duty(input longint q);
        longint d;
        if (q <= 0) begin
            return 0;
        end
        d = q >> FRAC_W;
        return (d > 255) ? 255 : d;
    endfunction

    function automatic t_drive predict_drive(input t_cfg k, input logic [SPEED_W-1:0] speed,
                                             input logic [DIST_W_DEF-1:0] c,
                                             input logic [DIST_W_DEF-1:0] l,
                                             input logic [DIST_W_DEF-1:0] r);
        longint tgt, diff, mag, step, bias, lim, spd;
        t_drive d;
        lim = longint'(k.max_bias) * 256;
        if (c <= k.stop) begin
            tgt = 0;
        end else if (c >= k.full) begin
            tgt = longint'(k.max_duty) * 256;
        end else begin
            diff = longint'(k.max_duty) - longint'(k.min_duty);
            mag  = (diff < 0) ? -diff : diff;
            step = ((longint'(c) - longint'(k.stop)) * mag * 256)
                   / (longint'(k.full) - longint'(k.stop));
            tgt  = longint'(k.min_duty) * 256 + ((diff < 0) ? -step : step);
        end

        bias = (longint'(r) - longint'(l)) * longint'(k.gain);
        if (bias > lim) begin
            bias = lim;
        end
        if (bias < -lim) begin
            bias = -lim;
        end

        if (tgt <= 0) begin
            spd = 0;
        end else begin
            spd = longint'(speed) + q8_trunc((tgt - longint'(speed)) * longint'(k.alpha));
            if (spd < 0) begin
                spd = 0;
            end
            if (spd > 65535) begin
                spd = 65535;
            end
        end

        d.left_duty      = '0;
        d.right_duty     = '0;
        if (spd > 0) begin
            d.left_duty  = DUTY_W'(wheel_duty(spd + bias));
            d.right_duty = DUTY_W'(wheel_duty(spd - bias));
        end
        d.smoothed_speed = spd[SPEED_W-1:0];
        d.target_speed   = tgt[SPEED_W-1:0];
        d.steer_bias     = BIAS_OUT_W'(q8_trunc(bias));
        return d;
    endfunction

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint got_v);
        if (exp_v != got_v) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg = '{stop: RST_STOP, full: RST_FULL, min_duty: RST_MIN_DUTY,
                    max_duty: RST_MAX_DUTY, alpha: RST_ALPHA, gain: RST_GAIN,
                    max_bias: RST_MAX_BIAS};
            speed_q88 = '0;
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_STOP:     cfg.stop     = i_cfg_data[DIST_CFG_W-1:0];
                    REG_FULL:     cfg.full     = i_cfg_data[DIST_CFG_W-1:0];
                    REG_MIN_DUTY: cfg.min_duty = i_cfg_data[DUTY_W-1:0];
                    REG_MAX_DUTY: cfg.max_duty = i_cfg_data[DUTY_W-1:0];
                    REG_ALPHA:    cfg.alpha    = i_cfg_data[ALPHA_W-1:0];
                    REG_GAIN:     cfg.gain     = i_cfg_data[GAIN_W-1:0];
                    REG_MAX_BIAS: cfg.max_bias = i_cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end

            if (in_ch.valid && in_ch.ready) begin
                want = predict_drive(cfg, speed_q88, in_ch.center_distance,
                                     in_ch.left_distance, in_ch.right_distance);
                speed_q88 = want.smoothed_speed;
                drive_q.push_back(want);
            end

            if (out_ch.valid && out_ch.ready) begin
                if (drive_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: drive command expected none, got speed %0d target %0d",
                                 $time, out_ch.smoothed_speed, out_ch.target_speed);
                    end
                end else begin
                    want = drive_q.pop_front();
                    checked++;
                    check_field("left_duty", longint'(want.left_duty),
                                longint'(out_ch.left_duty));
                    check_field("right_duty", longint'(want.right_duty),
                                longint'(out_ch.right_duty));
                    check_field("smoothed_speed", longint'(want.smoothed_speed),
                                longint'(out_ch.smoothed_speed));
                    check_field("target_speed", longint'(want.target_speed),
                                longint'(out_ch.target_speed));
                    check_field("steer_bias", longint'(want.steer_bias),
                                longint'(out_ch.steer_bias));
                end
            end
        end
        o_errors  <= errors;
        o_pending <= drive_q.size();
        o_checked <= checked;
    end

endmodule

// ===== bench/obstacle_speed_steer_control_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Obstacle speed/steer control testbench
// Drives sensor requests in random bursts against a randomly stalling drive
// channel, reprograms the control registers between drained phases, and
// leaves prediction and comparison to the drive command checker.
// ----------------------------------------------------------------------------
module obstacle_speed_steer_control_core_tb;
    import ossc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam int SETTLE      = 48;
    localparam int LIMIT       = 1500000;
    localparam int RAND_PHASES = 12;
    localparam int RAND_ITEMS  = 152;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errs;
    int pending;
    int checked;
    int cycles = 0;
    int sent = 0;
    int settings = 1;
    int burst_left = 0;
    int stop_sh = RST_STOP;
    int full_sh = RST_FULL;

    ossc_in_if  in_ch ();
    ossc_out_if out_ch ();

    obstacle_speed_steer_control_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ossc_drive_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errs),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("obstacle_speed_steer_control_core_tb: errors");
            $finish;
        end
    end

    // drive channel back-pressure: windows of differing ready density
    initial begin : drive_stall
        int window;
        int pct;
        window = 0;
        pct = 100;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (window == 0) begin
                case ($urandom_range(0, 3))
                    0: pct = 100;
                    1: pct = 75;
                    2: pct = 40;
                    default: pct = 8;
                endcase
                window = $urandom_range(30, 160);
            end
            window--;
            out_ch.ready <= ($urandom_range(0, 99) < pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_control(input int stop, input int full, input int min_d,
                               input int max_d, input int alpha, input int gain,
                               input int max_b);
        write_reg(REG_STOP, stop);
        write_reg(REG_FULL, full);
        write_reg(REG_MIN_DUTY, min_d);
        write_reg(REG_MAX_DUTY, max_d);
        write_reg(REG_ALPHA, alpha);
        write_reg(REG_GAIN, gain);
        write_reg(REG_MAX_BIAS, max_b);
        // out-of-range index must be ignored
        write_reg(REG_UNUSED, $urandom);
        cfg_we <= 1'b0;
        stop_sh = stop & 12'hFFF;
        full_sh = full & 12'hFFF;
        settings++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_sensors(input int c, input int l, input int r);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 45)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        in_ch.valid           <= 1'b1;
        in_ch.center_distance <= c[DIST_W_DEF-1:0];
        in_ch.left_distance   <= l[DIST_W_DEF-1:0];
        in_ch.right_distance  <= r[DIST_W_DEF-1:0];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        sent++;
    endtask

    function automatic int with_noise(input int v, input int w);
        if ($urandom_range(0, 1) == 0) begin
            return v;
        end
        return v | (int'($urandom_range(0, 4095)) & ~((1 << w) - 1));
    endfunction

    function automatic int pick_duty();
        int k;
        k = $urandom_range(0, 19);
        if (k < 3) begin
            return 0;
        end
        if (k < 6) begin
            return 255;
        end
        return $urandom_range(0, 255);
    endfunction

    function automatic int pick_center();
        int k;
        int c;
        k = $urandom_range(0, 99);
        if (k < 50 && full_sh > stop_sh + 1) begin
            c = $urandom_range(stop_sh + 1, full_sh - 1);
        end else if (k < 70) begin
            c = $urandom_range(full_sh, 4095);
        end else if (k < 80) begin
            case ($urandom_range(0, 5))
                0: c = stop_sh - 1;
                1: c = stop_sh;
                2: c = stop_sh + 1;
                3: c = full_sh - 1;
                4: c = full_sh;
                default: c = full_sh + 1;
            endcase
        end else if (k < 90) begin
            c = $urandom_range(0, stop_sh);
        end else begin
            c = $urandom_range(0, 4095);
        end
        return c & 12'hFFF;
    endfunction

    initial begin : stimulus
        int ph;
        int k;
        int st;
        int fu;
        int al;
        int l;
        int r;

        i_rst_n               <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.center_distance <= '0;
        in_ch.left_distance   <= '0;
        in_ch.right_distance  <= '0;
        cfg_we                <= 1'b0;
        cfg_idx               <= '0;
        cfg_data              <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: stop zone, ramp edges, full speed, bias clamps
        send_sensors(0, 0, 0);
        send_sensors(200, 4095, 0);
        send_sensors(201, 0, 4095);
        send_sensors(4095, 1000, 1000);
        send_sensors(4095, 0, 4095);
        send_sensors(4095, 4095, 0);
        send_sensors(1000, 500, 520);
        send_sensors(999, 2048, 2047);
        send_sensors(600, 100, 140);
        send_sensors(200, 300, 100);

        // ramp truncates to a zero target
        wait_drained();
        set_control(0, 4095, 0, 1, 256, 4095, 255);
        send_sensors(1, 10, 20);
        send_sensors(4095, 0, 1);

        // filter overshoot with saturation, oversized register data
        wait_drained();
        set_control(0, 4095, 12'hF00, 255, 12'hFFF, 12'hFFF, 12'hFFF);
        send_sensors(4095, 0, 4095);
        send_sensors(4095, 4095, 0);
        send_sensors(1, 2000, 2000);

        // stop not below full, zero filter weight
        wait_drained();
        set_control(3000, 100, 0, 255, 0, 0, 0);
        send_sensors(3001, 0, 4095);
        send_sensors(2000, 10, 10);
        send_sensors(4095, 4095, 0);

        // falling ramp
        wait_drained();
        set_control(100, 4000, 255, 10, 128, 300, 100);
        send_sensors(101, 1500, 1600);
        send_sensors(2000, 1700, 1600);
        send_sensors(3999, 0, 0);
        send_sensors(4000, 12, 3000);

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            k = $urandom_range(0, 9);
            st = (k == 0) ? 0 : (k == 1) ? 4095 : $urandom_range(0, 2000);
            k = $urandom_range(0, 9);
            if (k < 7 && st < 4095) begin
                fu = $urandom_range(st + 1, 4095);
            end else if (k < 9) begin
                fu = $urandom_range(0, st);
            end else begin
                fu = $urandom_range(0, 4095);
            end
            k = $urandom_range(0, 9);
            al = (k < 6) ? $urandom_range(1, 256) :
                 (k < 8) ? $urandom_range(257, 511) :
                 (k < 9) ? 0 : 256;
            set_control(st, fu, with_noise(pick_duty(), DUTY_W),
                        with_noise(pick_duty(), DUTY_W), with_noise(al, ALPHA_W),
                        $urandom_range(0, 4095), with_noise(pick_duty(), DUTY_W));
            repeat (RAND_ITEMS) begin
                l = $urandom_range(0, 4095);
                k = $urandom_range(0, 9);
                if (k < 4) begin
                    r = $urandom_range(0, 4095);
                end else if (k < 8) begin
                    r = l + int'($urandom_range(0, 80)) - 40;
                    r = (r < 0) ? 0 : (r > 4095) ? 4095 : r;
                end else begin
                    r = l;
                end
                send_sensors(pick_center(), l, r);
            end
        end

        wait_drained();
        $display("covered %0d sensor requests under %0d register settings, %0d commands compared",
                 sent, settings, checked);
        if (errs == 0) begin
            $display("obstacle_speed_steer_control_core_tb: clean");
        end else begin
            $display("obstacle_speed_steer_control_core_tb: errors");
        end
        $finish;
    end

endmodule
